>>> hdl/pose_kalman_filter_outlier_gate_macros.svh
// ----------------------------------------------------------------------------
// pose_kalman_filter_outlier_gate_macros
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef POSE_KALMAN_FILTER_OUTLIER_GATE_MACROS_SVH
`define POSE_KALMAN_FILTER_OUTLIER_GATE_MACROS_SVH

// Concurrent assertion with an explicit clock and active-low reset.
`define PKFOG_ASSERT_CLKRST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);

// Same, on the block's standard clock and reset names.
`define PKFOG_ASSERT(lbl, prop, msg) `PKFOG_ASSERT_CLKRST(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/pkfog_pkg.sv
// ----------------------------------------------------------------------------
// pkfog_pkg
// Shared constants, types, microcode and saturating helpers for the pose
// Kalman filter with outlier gate.
// ----------------------------------------------------------------------------
package pkfog_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COV_WIDTH = 48;
  localparam int DW        = 64;      // scratch datapath width
  localparam int SW        = DW + 2;  // sum width before saturation
  localparam int HW        = DW / 2;  // multiplier slice width
  localparam int MEAS_W    = 32;
  localparam int PERIOD_W  = 20;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int STATUS_W  = 2;
  localparam int LANES     = 3;
  localparam int LANE_W    = 2;
  localparam int UC_AW     = 6;

  localparam logic [LANE_W-1:0] HEADING_LANE = LANE_W'(2);

  // n / 10^6 = ((n >> 6) * MEGA_RECIP) >> 45, exact for n < 2^37
  localparam int            MEGA_PRE_SHIFT   = 6;
  localparam int            MEGA_RECIP_SHIFT = 45;
  localparam logic [DW-1:0] MEGA_RECIP       = DW'(64'd2251799814);
  localparam logic [DW-1:0] HALF_MEGA        = DW'(500000);

  localparam logic [PERIOD_W-1:0]  PERIOD_RST     = PERIOD_W'(33333);
  localparam logic [CFG_W-1:0]     VAR_RST        = CFG_W'(65536);
  localparam logic [CFG_W-1:0]     POS_GATE_RST   = CFG_W'(655);
  localparam logic [CFG_W-1:0]     ANGLE_GATE_RST = CFG_W'(11438);
  localparam logic [COV_WIDTH-1:0] INIT_COV       = COV_WIDTH'(65536);

  localparam logic [UC_AW-1:0] UC_LANE_START = UC_AW'(4);
  localparam logic [UC_AW-1:0] UC_LAST       = UC_AW'(37);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD, CFG_ACCEL, CFG_ROT_ACCEL, CFG_POS_MEAS,
    CFG_ANGLE_MEAS, CFG_INIT_COV, CFG_POS_GATE, CFG_ANGLE_GATE
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK, STATUS_OUTLIER, STATUS_NO_DET
  } status_e;

  typedef enum logic [2:0] {
    OP_MUL, OP_DIVQ, OP_DIVT, OP_ADD, OP_SUB, OP_RSH, OP_GATE
  } op_e;

  typedef enum logic [1:0] {WID_32, WID_62, WID_COV, WID_64} wid_e;

  typedef enum logic [4:0] {
    SEL_ZERO, SEL_T, SEL_T2, SEL_T3, SEL_T4, SEL_TMP, SEL_Q00, SEL_Q01,
    SEL_Q11, SEL_PP, SEL_TP01, SEL_TP11, SEL_P00, SEL_P01, SEL_P11, SEL_S,
    SEL_Y, SEL_K0, SEL_K1, SEL_POS, SEL_RATE, SEL_C00, SEL_C01, SEL_C11,
    SEL_ACC, SEL_MEASR, SEL_MEASZ, SEL_GATE, SEL_PERIOD, SEL_MEGA,
    SEL_PREDP, SEL_PREDV
  } sel_e;

  typedef struct packed {
    op_e        op;
    sel_e       dst;
    sel_e       src_a;
    sel_e       src_b;
    wid_e       wid;
    logic [1:0] shift;
  } uc_t;

  typedef struct packed {
    logic start;
    op_e  op;
    wid_e wid;
  } au_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] res;
  } au_rsp_t;

  function automatic int wid_bits(input wid_e w);
    int n;
    case (w)
      WID_32:  n = 32;
      WID_62:  n = 62;
      WID_COV: n = COV_WIDTH;
      default: n = DW;
    endcase
    return n;
  endfunction

  function automatic logic signed [DW-1:0] sat(input logic signed [SW-1:0] x,
                                               input wid_e w);
    logic signed [SW-1:0] one, hi, lo;
    logic signed [SW-1:0] r;
    one = SW'(1);
    hi  = (one <<< (wid_bits(w) - 1)) - one;
    lo  = -hi - one;
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end else begin
      r = x;
    end
    return r[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] magn(input logic signed [DW-1:0] x);
    logic [DW-1:0] r;
    r = x[DW-1] ? unsigned'(-x) : unsigned'(x);
    return r;
  endfunction

  // magnitude to signed value, clipped to the signed range then to w bits
  function automatic logic signed [DW-1:0] apply_sign(input logic [DW-1:0] m,
                                                      input logic neg,
                                                      input wid_e w);
    logic [DW-1:0]        mm;
    logic signed [SW-1:0] v;
    mm = m[DW-1] ? {1'b0, {(DW-1){1'b1}}} : m;
    v  = signed'({2'b00, mm});
    if (neg) begin
      v = -v;
    end
    return sat(v, w);
  endfunction

  // Per-item program: period setup, then one lane pass run three times.
  function automatic uc_t uc_rom(input logic [UC_AW-1:0] a);
    uc_t r;
    case (a)
      6'd0:  r = '{OP_DIVT, SEL_T,     SEL_PERIOD, SEL_MEGA,  WID_64,  2'd0};
      6'd1:  r = '{OP_MUL,  SEL_T2,    SEL_T,      SEL_T,     WID_64,  2'd0};
      6'd2:  r = '{OP_MUL,  SEL_T3,    SEL_T2,     SEL_T,     WID_64,  2'd0};
      6'd3:  r = '{OP_MUL,  SEL_T4,    SEL_T3,     SEL_T,     WID_64,  2'd0};
      6'd4:  r = '{OP_MUL,  SEL_TMP,   SEL_T4,     SEL_ACC,   WID_62,  2'd0};
      6'd5:  r = '{OP_RSH,  SEL_Q00,   SEL_TMP,    SEL_ZERO,  WID_COV, 2'd2};
      6'd6:  r = '{OP_MUL,  SEL_TMP,   SEL_T3,     SEL_ACC,   WID_62,  2'd0};
      6'd7:  r = '{OP_RSH,  SEL_Q01,   SEL_TMP,    SEL_ZERO,  WID_COV, 2'd1};
      6'd8:  r = '{OP_MUL,  SEL_Q11,   SEL_T2,     SEL_ACC,   WID_COV, 2'd0};
      6'd9:  r = '{OP_MUL,  SEL_TMP,   SEL_T,      SEL_RATE,  WID_32,  2'd0};
      6'd10: r = '{OP_ADD,  SEL_PP,    SEL_POS,    SEL_TMP,   WID_32,  2'd0};
      6'd11: r = '{OP_MUL,  SEL_TP01,  SEL_T,      SEL_C01,   WID_COV, 2'd0};
      6'd12: r = '{OP_MUL,  SEL_TP11,  SEL_T,      SEL_C11,   WID_COV, 2'd0};
      6'd13: r = '{OP_ADD,  SEL_P00,   SEL_C00,    SEL_TP01,  WID_COV, 2'd0};
      6'd14: r = '{OP_ADD,  SEL_P00,   SEL_P00,    SEL_TP01,  WID_COV, 2'd0};
      6'd15: r = '{OP_MUL,  SEL_TMP,   SEL_T,      SEL_TP11,  WID_COV, 2'd0};
      6'd16: r = '{OP_ADD,  SEL_P00,   SEL_P00,    SEL_TMP,   WID_COV, 2'd0};
      6'd17: r = '{OP_ADD,  SEL_P00,   SEL_P00,    SEL_Q00,   WID_COV, 2'd0};
      6'd18: r = '{OP_ADD,  SEL_P01,   SEL_C01,    SEL_TP11,  WID_COV, 2'd0};
      6'd19: r = '{OP_ADD,  SEL_P01,   SEL_P01,    SEL_Q01,   WID_COV, 2'd0};
      6'd20: r = '{OP_ADD,  SEL_P11,   SEL_C11,    SEL_Q11,   WID_COV, 2'd0};
      6'd21: r = '{OP_ADD,  SEL_S,     SEL_P00,    SEL_MEASR, WID_COV, 2'd0};
      6'd22: r = '{OP_SUB,  SEL_Y,     SEL_MEASZ,  SEL_PP,    WID_64,  2'd0};
      6'd23: r = '{OP_DIVQ, SEL_K0,    SEL_P00,    SEL_S,     WID_COV, 2'd0};
      6'd24: r = '{OP_DIVQ, SEL_K1,    SEL_P01,    SEL_S,     WID_COV, 2'd0};
      6'd25: r = '{OP_GATE, SEL_ZERO,  SEL_Y,      SEL_GATE,  WID_64,  2'd0};
      6'd26: r = '{OP_ADD,  SEL_PREDP, SEL_PP,     SEL_ZERO,  WID_64,  2'd0};
      6'd27: r = '{OP_ADD,  SEL_PREDV, SEL_RATE,   SEL_ZERO,  WID_64,  2'd0};
      6'd28: r = '{OP_MUL,  SEL_TMP,   SEL_K0,     SEL_Y,     WID_32,  2'd0};
      6'd29: r = '{OP_ADD,  SEL_POS,   SEL_PP,     SEL_TMP,   WID_32,  2'd0};
      6'd30: r = '{OP_MUL,  SEL_TMP,   SEL_K1,     SEL_Y,     WID_32,  2'd0};
      6'd31: r = '{OP_ADD,  SEL_RATE,  SEL_RATE,   SEL_TMP,   WID_32,  2'd0};
      6'd32: r = '{OP_MUL,  SEL_TMP,   SEL_K0,     SEL_P00,   WID_COV, 2'd0};
      6'd33: r = '{OP_SUB,  SEL_C00,   SEL_P00,    SEL_TMP,   WID_COV, 2'd0};
      6'd34: r = '{OP_MUL,  SEL_TMP,   SEL_K0,     SEL_P01,   WID_COV, 2'd0};
      6'd35: r = '{OP_SUB,  SEL_C01,   SEL_P01,    SEL_TMP,   WID_COV, 2'd0};
      6'd36: r = '{OP_MUL,  SEL_TMP,   SEL_K1,     SEL_P01,   WID_COV, 2'd0};
      6'd37: r = '{OP_SUB,  SEL_C11,   SEL_P11,    SEL_TMP,   WID_COV, 2'd0};
      default: r = '{OP_ADD, SEL_ZERO, SEL_ZERO,   SEL_ZERO,  WID_64,  2'd0};
    endcase
    return r;
  endfunction

endpackage

>>> hdl/pkfog_if.sv
// ----------------------------------------------------------------------------
// pkfog_meas_if / pkfog_pose_if
// Valid/ready channels for measurement requests and filtered pose results.
// ----------------------------------------------------------------------------
interface pkfog_meas_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pkfog_pkg::MEAS_W-1:0]   meas_x;
  logic signed [pkfog_pkg::MEAS_W-1:0]   meas_y;
  logic signed [pkfog_pkg::MEAS_W-1:0]   meas_heading;
  logic                                  detected;

  modport source (output valid, meas_x, meas_y, meas_heading, detected, input ready);
  modport sink   (input valid, meas_x, meas_y, meas_heading, detected, output ready);
endinterface

interface pkfog_pose_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pkfog_pkg::MEAS_W-1:0]   out_x;
  logic signed [pkfog_pkg::MEAS_W-1:0]   out_x_rate;
  logic signed [pkfog_pkg::MEAS_W-1:0]   out_y;
  logic signed [pkfog_pkg::MEAS_W-1:0]   out_y_rate;
  logic signed [pkfog_pkg::MEAS_W-1:0]   out_heading;
  logic signed [pkfog_pkg::MEAS_W-1:0]   out_heading_rate;
  logic [pkfog_pkg::STATUS_W-1:0]        status;

  modport source (output valid, out_x, out_x_rate, out_y, out_y_rate, out_heading,
                  out_heading_rate, status, input ready);
  modport sink   (input valid, out_x, out_x_rate, out_y, out_y_rate, out_heading,
                  out_heading_rate, status, output ready);
endinterface

>>> hdl/pkfog_arith.sv
// ----------------------------------------------------------------------------
// pkfog_arith
// Shared multicycle unit: Q-format multiply from four 32x32 partial
// products, a reciprocal multiply for the sample-time scaling, and a
// one-bit-per-cycle shift-subtract divider.
// ----------------------------------------------------------------------------
module pkfog_arith (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pkfog_pkg::au_req_t            req_i,
  input  logic signed [pkfog_pkg::DW-1:0] a_i,
  input  logic signed [pkfog_pkg::DW-1:0] b_i,
  output pkfog_pkg::au_rsp_t            rsp_o
);

  localparam int DW  = pkfog_pkg::DW;
  localparam int HW  = pkfog_pkg::HW;
  localparam int FB  = pkfog_pkg::FRAC_BITS;
  localparam int DCW = $clog2(DW);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MULP = 3'd1;
  localparam logic [2:0] A_MULA = 3'd2;
  localparam logic [2:0] A_MULF = 3'd3;
  localparam logic [2:0] A_DIV  = 3'd4;
  localparam logic [2:0] A_DIVF = 3'd5;

  logic [2:0]             state_q, state_d;
  logic                   done_q, done_d;
  logic [DW-1:0]          x_q, x_d, y_q, y_d;
  logic                   neg_q, neg_d;
  logic                   trunc_q, trunc_d;
  pkfog_pkg::wid_e        wid_q, wid_d;
  logic [2*DW-1:0]        acc_q, acc_d;
  logic [DW-1:0]          prod_q, prod_d;
  logic [1:0]             pcnt_q, pcnt_d;
  logic [DW-1:0]          rem_q, rem_d, lo_q, lo_d, quo_q, quo_d;
  logic [DCW-1:0]         dcnt_q, dcnt_d;
  logic signed [DW-1:0]   res_q, res_d;

  logic [HW-1:0]          ah, bh;
  logic [2*DW-1:0]        rnd;
  logic [DW-1:0]          mq, m_in, hi_in;
  logic [DW:0]            rem2;
  logic                   ge;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    x_d     = x_q;
    y_d     = y_q;
    neg_d   = neg_q;
    trunc_d = trunc_q;
    wid_d   = wid_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    pcnt_d  = pcnt_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    quo_d   = quo_q;
    dcnt_d  = dcnt_q;
    res_d   = res_q;

    ah    = pcnt_q[1] ? x_q[DW-1:HW] : x_q[HW-1:0];
    bh    = pcnt_q[0] ? y_q[DW-1:HW] : y_q[HW-1:0];
    rnd   = acc_q + ((2*DW)'(1) << (FB - 1));
    mq    = (|rnd[2*DW-1:DW+FB]) ? '1 : rnd[DW+FB-1:FB];
    m_in  = pkfog_pkg::magn(a_i);
    hi_in = m_in >> (DW - FB);
    rem2  = {rem_q, lo_q[DW-1]};
    ge    = rem2 >= {1'b0, y_q};

    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          wid_d   = req_i.wid;
          quo_d   = '0;
          dcnt_d  = DCW'(DW - 1);
          trunc_d = 1'b0;
          case (req_i.op)
            pkfog_pkg::OP_MUL: begin
              x_d     = pkfog_pkg::magn(a_i);
              y_d     = pkfog_pkg::magn(b_i);
              neg_d   = a_i[DW-1] ^ b_i[DW-1];
              acc_d   = '0;
              pcnt_d  = '0;
              state_d = A_MULP;
            end
            pkfog_pkg::OP_DIVT: begin
              // n / 10^6 as (n >> 6) / 15625, by reciprocal multiply and truncation
              x_d     = unsigned'(a_i) >> pkfog_pkg::MEGA_PRE_SHIFT;
              y_d     = b_i;
              neg_d   = 1'b0;
              acc_d   = '0;
              pcnt_d  = '0;
              trunc_d = 1'b1;
              state_d = A_MULP;
            end
            pkfog_pkg::OP_DIVQ: begin
              neg_d = a_i[DW-1];
              if (b_i <= 0) begin
                res_d  = '0;
                done_d = 1'b1;
              end else if (hi_in >= unsigned'(b_i)) begin
                res_d  = pkfog_pkg::apply_sign('1, a_i[DW-1], req_i.wid);
                done_d = 1'b1;
              end else begin
                rem_d   = hi_in;
                lo_d    = m_in << FB;
                y_d     = b_i;
                state_d = A_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      A_MULP: begin
        prod_d  = ah * bh;
        state_d = A_MULA;
      end
      A_MULA: begin
        acc_d   = acc_q + ({{DW{1'b0}}, prod_q} << (HW * (int'(pcnt_q[1]) + int'(pcnt_q[0]))));
        pcnt_d  = pcnt_q + 2'd1;
        state_d = (pcnt_q == 2'd3) ? A_MULF : A_MULP;
      end
      A_MULF: begin
        if (trunc_q) begin
          res_d = signed'(DW'(acc_q >> pkfog_pkg::MEGA_RECIP_SHIFT));
        end else begin
          res_d = pkfog_pkg::apply_sign(mq, neg_q, wid_q);
        end
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      A_DIV: begin
        rem_d  = ge ? DW'(rem2 - {1'b0, y_q}) : rem2[DW-1:0];
        quo_d  = {quo_q[DW-2:0], ge};
        lo_d   = lo_q << 1;
        dcnt_d = dcnt_q - DCW'(1);
        if (dcnt_q == '0) begin
          state_d = A_DIVF;
        end
      end
      A_DIVF: begin
        res_d   = pkfog_pkg::apply_sign(quo_q, neg_q, wid_q);
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    neg_q   <= neg_d;
    trunc_q <= trunc_d;
    wid_q   <= wid_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    pcnt_q  <= pcnt_d;
    rem_q   <= rem_d;
    lo_q    <= lo_d;
    quo_q   <= quo_d;
    dcnt_q  <= dcnt_d;
    res_q   <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

>>> hdl/pose_kalman_filter_outlier_gate.sv
// ----------------------------------------------------------------------------
// pose_kalman_filter_outlier_gate
// Constant-velocity Kalman filter on x, y and heading with an innovation gate.
// ----------------------------------------------------------------------------
// One measurement request is taken while the block is idle and produces one
// pose result. A small microcoded sequencer runs a setup pass (sample time
// and its powers) and then the same predict/correct pass on each of the three
// lanes, driving one shared multicycle unit: a multiply is built from four
// 32x32 partial products and a divide yields one quotient bit per cycle,
// ending early when the divisor is not positive or the quotient saturates.
// The sample time is scaled by a reciprocal multiply. An item's run time is
// dominated by the six divides and forty multiplies. The result sits in an
// output register, so the next request is accepted as soon as the sequencer
// is idle, even if the last result has not been taken yet; that next item then
// waits at its end until the register is free.
// ----------------------------------------------------------------------------
module pose_kalman_filter_outlier_gate (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pkfog_meas_if.sink                         meas_i,
  pkfog_pose_if.source                       pose_o,
  input  logic                               cfg_we_i,
  input  logic [pkfog_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pkfog_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int DW  = pkfog_pkg::DW;
  localparam int SW  = pkfog_pkg::SW;
  localparam int MW  = pkfog_pkg::MEAS_W;
  localparam int CW  = pkfog_pkg::COV_WIDTH;
  localparam int NL  = pkfog_pkg::LANES;
  localparam int LW  = pkfog_pkg::LANE_W;
  localparam int UAW = pkfog_pkg::UC_AW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]     state_q, state_d;
  logic [UAW-1:0] upc_q, upc_d;
  logic [LW-1:0]  lane_q, lane_d;
  logic           pass_q, pass_d;
  logic           out_valid_q, out_valid_d;

  logic [pkfog_pkg::PERIOD_W-1:0] period_q;
  logic [pkfog_pkg::CFG_W-1:0]    accel_q, rot_accel_q, pos_meas_q, angle_meas_q;
  logic [pkfog_pkg::CFG_W-1:0]    pos_gate_q, angle_gate_q;

  logic signed [MW-1:0] z_q [NL];
  logic                 det_q;

  logic signed [DW-1:0] t_q, t2_q, t3_q, t4_q, tmp_q, q00_q, q01_q, q11_q;
  logic signed [DW-1:0] pp_q, tp01_q, tp11_q, p00_q, p01_q, p11_q, s_q, y_q;
  logic signed [DW-1:0] k0_q, k1_q;

  logic signed [MW-1:0] pos_q [NL];
  logic signed [MW-1:0] rate_q [NL];
  logic signed [CW-1:0] c00_q [NL];
  logic signed [CW-1:0] c01_q [NL];
  logic signed [CW-1:0] c11_q [NL];
  logic signed [MW-1:0] predp_q [NL];
  logic signed [MW-1:0] predv_q [NL];

  logic signed [MW-1:0]         ox_q, oxr_q, oy_q, oyr_q, oh_q, ohr_q;
  pkfog_pkg::status_e           status_q;

  pkfog_pkg::uc_t     uc;
  pkfog_pkg::au_req_t au_req;
  pkfog_pkg::au_rsp_t au_rsp;

  logic signed [DW-1:0] opa, opb, alu_res, wr_val;
  logic signed [SW-1:0] sa, sb;
  logic [DW-1:0]        ay;
  logic                 wr_en, step, load, accept, use_est;

  function automatic logic signed [DW-1:0] opnd(input pkfog_pkg::sel_e s);
    logic signed [DW-1:0] v;
    case (s)
      pkfog_pkg::SEL_T:      v = t_q;
      pkfog_pkg::SEL_T2:     v = t2_q;
      pkfog_pkg::SEL_T3:     v = t3_q;
      pkfog_pkg::SEL_T4:     v = t4_q;
      pkfog_pkg::SEL_TMP:    v = tmp_q;
      pkfog_pkg::SEL_Q00:    v = q00_q;
      pkfog_pkg::SEL_Q01:    v = q01_q;
      pkfog_pkg::SEL_Q11:    v = q11_q;
      pkfog_pkg::SEL_PP:     v = pp_q;
      pkfog_pkg::SEL_TP01:   v = tp01_q;
      pkfog_pkg::SEL_TP11:   v = tp11_q;
      pkfog_pkg::SEL_P00:    v = p00_q;
      pkfog_pkg::SEL_P01:    v = p01_q;
      pkfog_pkg::SEL_P11:    v = p11_q;
      pkfog_pkg::SEL_S:      v = s_q;
      pkfog_pkg::SEL_Y:      v = y_q;
      pkfog_pkg::SEL_K0:     v = k0_q;
      pkfog_pkg::SEL_K1:     v = k1_q;
      pkfog_pkg::SEL_POS:    v = DW'(pos_q[lane_q]);
      pkfog_pkg::SEL_RATE:   v = DW'(rate_q[lane_q]);
      pkfog_pkg::SEL_C00:    v = DW'(c00_q[lane_q]);
      pkfog_pkg::SEL_C01:    v = DW'(c01_q[lane_q]);
      pkfog_pkg::SEL_C11:    v = DW'(c11_q[lane_q]);
      pkfog_pkg::SEL_ACC:
        v = signed'(DW'((lane_q == pkfog_pkg::HEADING_LANE) ? rot_accel_q : accel_q));
      pkfog_pkg::SEL_MEASR:
        v = signed'(DW'((lane_q == pkfog_pkg::HEADING_LANE) ? angle_meas_q : pos_meas_q));
      pkfog_pkg::SEL_GATE:
        v = signed'(DW'((lane_q == pkfog_pkg::HEADING_LANE) ? angle_gate_q : pos_gate_q));
      pkfog_pkg::SEL_MEASZ:  v = DW'(z_q[lane_q]);
      pkfog_pkg::SEL_PERIOD:
        v = signed'((DW'(period_q) << pkfog_pkg::FRAC_BITS) + pkfog_pkg::HALF_MEGA);
      pkfog_pkg::SEL_MEGA:   v = signed'(pkfog_pkg::MEGA_RECIP);
      default:               v = '0;
    endcase
    return v;
  endfunction

  assign accept       = meas_i.valid && meas_i.ready;
  assign meas_i.ready = (state_q == ST_IDLE);
  assign use_est      = det_q && pass_q;

  always_comb begin
    uc  = pkfog_pkg::uc_rom(upc_q);
    opa = opnd(uc.src_a);
    opb = opnd(uc.src_b);
    sa  = SW'(opa);
    sb  = SW'(opb);
    ay  = pkfog_pkg::magn(opa);

    case (uc.op)
      pkfog_pkg::OP_ADD: alu_res = pkfog_pkg::sat(sa + sb, uc.wid);
      pkfog_pkg::OP_SUB: alu_res = pkfog_pkg::sat(sa - sb, uc.wid);
      // round half up, then arithmetic shift
      pkfog_pkg::OP_RSH:
        alu_res = pkfog_pkg::sat((sa + (SW'(1) <<< (uc.shift - 2'd1))) >>> uc.shift, uc.wid);
      default:           alu_res = opa;
    endcase

    state_d = state_q;
    upc_d   = upc_q;
    lane_d  = lane_q;
    pass_d  = pass_q;
    wr_en   = 1'b0;
    wr_val  = alu_res;
    step    = 1'b0;
    load    = 1'b0;
    au_req  = '{start: 1'b0, op: uc.op, wid: uc.wid};

    case (state_q)
      ST_IDLE: begin
        if (meas_i.valid) begin
          state_d = ST_EXEC;
          upc_d   = '0;
          lane_d  = '0;
          pass_d  = 1'b1;
        end
      end
      ST_EXEC: begin
        if (uc.op == pkfog_pkg::OP_MUL || uc.op == pkfog_pkg::OP_DIVQ ||
            uc.op == pkfog_pkg::OP_DIVT) begin
          au_req.start = 1'b1;
          state_d      = ST_WAIT;
        end else begin
          if (uc.op == pkfog_pkg::OP_GATE) begin
            pass_d = pass_q && (ay < DW'(opb));
          end else begin
            wr_en = 1'b1;
          end
          step = 1'b1;
        end
      end
      ST_WAIT: begin
        if (au_rsp.done) begin
          wr_en   = 1'b1;
          wr_val  = au_rsp.res;
          step    = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || pose_o.ready) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (step) begin
      if (upc_q == pkfog_pkg::UC_LAST) begin
        if (lane_q == LW'(NL - 1)) begin
          state_d = ST_DONE;
        end else begin
          lane_d = lane_q + LW'(1);
          upc_d  = pkfog_pkg::UC_LANE_START;
        end
      end else begin
        upc_d = upc_q + UAW'(1);
      end
    end

    out_valid_d = load ? 1'b1 : (pose_o.ready ? 1'b0 : out_valid_q);
  end

  pkfog_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (au_req),
    .a_i    (opa),
    .b_i    (opb),
    .rsp_o  (au_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      upc_q       <= '0;
      lane_q      <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      upc_q       <= upc_d;
      lane_q      <= lane_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers; initial covariance only applies at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= pkfog_pkg::PERIOD_RST;
      accel_q      <= pkfog_pkg::VAR_RST;
      rot_accel_q  <= pkfog_pkg::VAR_RST;
      pos_meas_q   <= pkfog_pkg::VAR_RST;
      angle_meas_q <= pkfog_pkg::VAR_RST;
      pos_gate_q   <= pkfog_pkg::POS_GATE_RST;
      angle_gate_q <= pkfog_pkg::ANGLE_GATE_RST;
    end else if (cfg_we_i) begin
      case (pkfog_pkg::cfg_idx_e'(cfg_index_i))
        pkfog_pkg::CFG_PERIOD:     period_q     <= cfg_data_i[pkfog_pkg::PERIOD_W-1:0];
        pkfog_pkg::CFG_ACCEL:      accel_q      <= cfg_data_i;
        pkfog_pkg::CFG_ROT_ACCEL:  rot_accel_q  <= cfg_data_i;
        pkfog_pkg::CFG_POS_MEAS:   pos_meas_q   <= cfg_data_i;
        pkfog_pkg::CFG_ANGLE_MEAS: angle_meas_q <= cfg_data_i;
        pkfog_pkg::CFG_INIT_COV:   ;
        pkfog_pkg::CFG_POS_GATE:   pos_gate_q   <= cfg_data_i;
        pkfog_pkg::CFG_ANGLE_GATE: angle_gate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // filter state per lane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NL; i++) begin
        pos_q[i]  <= '0;
        rate_q[i] <= '0;
        c00_q[i]  <= pkfog_pkg::INIT_COV;
        c01_q[i]  <= '0;
        c11_q[i]  <= pkfog_pkg::INIT_COV;
      end
    end else if (wr_en) begin
      case (uc.dst)
        pkfog_pkg::SEL_POS:  pos_q[lane_q]  <= wr_val[MW-1:0];
        pkfog_pkg::SEL_RATE: rate_q[lane_q] <= wr_val[MW-1:0];
        pkfog_pkg::SEL_C00:  c00_q[lane_q]  <= wr_val[CW-1:0];
        pkfog_pkg::SEL_C01:  c01_q[lane_q]  <= wr_val[CW-1:0];
        pkfog_pkg::SEL_C11:  c11_q[lane_q]  <= wr_val[CW-1:0];
        default: ;
      endcase
    end
  end

  // scratch, request capture and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      z_q[0] <= meas_i.meas_x;
      z_q[1] <= meas_i.meas_y;
      z_q[2] <= meas_i.meas_heading;
      det_q  <= meas_i.detected;
    end
    if (wr_en) begin
      case (uc.dst)
        pkfog_pkg::SEL_T:     t_q    <= wr_val;
        pkfog_pkg::SEL_T2:    t2_q   <= wr_val;
        pkfog_pkg::SEL_T3:    t3_q   <= wr_val;
        pkfog_pkg::SEL_T4:    t4_q   <= wr_val;
        pkfog_pkg::SEL_TMP:   tmp_q  <= wr_val;
        pkfog_pkg::SEL_Q00:   q00_q  <= wr_val;
        pkfog_pkg::SEL_Q01:   q01_q  <= wr_val;
        pkfog_pkg::SEL_Q11:   q11_q  <= wr_val;
        pkfog_pkg::SEL_PP:    pp_q   <= wr_val;
        pkfog_pkg::SEL_TP01:  tp01_q <= wr_val;
        pkfog_pkg::SEL_TP11:  tp11_q <= wr_val;
        pkfog_pkg::SEL_P00:   p00_q  <= wr_val;
        pkfog_pkg::SEL_P01:   p01_q  <= wr_val;
        pkfog_pkg::SEL_P11:   p11_q  <= wr_val;
        pkfog_pkg::SEL_S:     s_q    <= wr_val;
        pkfog_pkg::SEL_Y:     y_q    <= wr_val;
        pkfog_pkg::SEL_K0:    k0_q   <= wr_val;
        pkfog_pkg::SEL_K1:    k1_q   <= wr_val;
        pkfog_pkg::SEL_PREDP: predp_q[lane_q] <= wr_val[MW-1:0];
        pkfog_pkg::SEL_PREDV: predv_q[lane_q] <= wr_val[MW-1:0];
        default: ;
      endcase
    end
    if (load) begin
      ox_q  <= use_est ? pos_q[0]  : predp_q[0];
      oxr_q <= use_est ? rate_q[0] : predv_q[0];
      oy_q  <= use_est ? pos_q[1]  : predp_q[1];
      oyr_q <= use_est ? rate_q[1] : predv_q[1];
      oh_q  <= use_est ? pos_q[2]  : predp_q[2];
      ohr_q <= use_est ? rate_q[2] : predv_q[2];
      if (!det_q) begin
        status_q <= pkfog_pkg::STATUS_NO_DET;
      end else if (pass_q) begin
        status_q <= pkfog_pkg::STATUS_OK;
      end else begin
        status_q <= pkfog_pkg::STATUS_OUTLIER;
      end
    end
  end

  assign pose_o.valid            = out_valid_q;
  assign pose_o.out_x            = ox_q;
  assign pose_o.out_x_rate       = oxr_q;
  assign pose_o.out_y            = oy_q;
  assign pose_o.out_y_rate       = oyr_q;
  assign pose_o.out_heading      = oh_q;
  assign pose_o.out_heading_rate = ohr_q;
  assign pose_o.status           = status_q;

endmodule

>>> hdl/pkfog_checker.sv
// ----------------------------------------------------------------------------
// pkfog_checker
// Port-level checks for the pose Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "pose_kalman_filter_outlier_gate_macros.svh"

module pkfog_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           meas_valid_i,
  input logic                           meas_ready_i,
  input logic                           pose_valid_i,
  input logic                           pose_ready_i,
  input logic [pkfog_pkg::STATUS_W-1:0] status_i
);

  // one request at a time: no new request right after one is taken
  `PKFOG_ASSERT(a_busy_after_req, (meas_valid_i && meas_ready_i) |=> !meas_ready_i, "ready after request")
  // a result never shows up the cycle after a request
  `PKFOG_ASSERT(a_no_instant_result, (meas_valid_i && meas_ready_i) |=> !$rose(pose_valid_i), "result too early")
  `PKFOG_ASSERT(a_valid_holds, (pose_valid_i && !pose_ready_i) |=> pose_valid_i, "result dropped")
  `PKFOG_ASSERT(a_status_holds, (pose_valid_i && !pose_ready_i) |=> $stable(status_i), "status changed")

endmodule

bind pose_kalman_filter_outlier_gate pkfog_checker u_pkfog_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .meas_valid_i (meas_i.valid),
  .meas_ready_i (meas_i.ready),
  .pose_valid_i (pose_o.valid),
  .pose_ready_i (pose_o.ready),
  .status_i     (pose_o.status)
);
